FILE: rtl/shs_pkg.sv
// shared types, constants and tables for the sha-256 stream hasher
// no dependencies; used by shs_ctrl, shs_dp and sha256_stream_hasher
package shs_pkg;

	localparam int COUNT_WIDTH_DEF = 61;

	// one input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	// one result transaction
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	// source of the byte shifted into the block window
	typedef enum logic [1:0] {
		BSEL_MSG  = 2'd0,
		BSEL_PAD  = 2'd1,
		BSEL_ZERO = 2'd2,
		BSEL_LEN  = 2'd3
	} byte_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic       shift_en;
		byte_sel_t  byte_sel;
		logic       count_inc;
		logic       count_clr;
		logic       vars_load;
		logic       round_en;
		logic [5:0] round_idx;
		logic       hash_add;
		logic       hash_init;
		logic [2:0] word_idx;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [5:0] fill;
	} sts_t;

	// initial hash value for word i
	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// round constant for round t
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98;
			6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;
			6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;
			6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;
			6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;
			6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;
			6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;
			6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;
			6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;
			6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;
			6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;
			6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;
			6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;
			6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;
			6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;
			6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;
			6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;
			6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;
			6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;
			6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;
			6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;
			6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;
			6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;
			6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			6'd63: r = 32'hc67178f2;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: input and result channels, controller and datapath
// depends on shs_pkg, shs_ctrl and shs_dp
//
// Hashes a byte stream with SHA-256. Each input transaction carries at most one
// message byte and may mark the end of the message; an end transaction with no byte
// finishes the message from the bytes already taken (no bytes gives the empty-message
// digest). While a block fills, one transaction is accepted per cycle. Every 64th
// message byte starts a compression that holds msg_ready low through 64 rounds
// of the single shared round unit and then the chaining update. An end transaction
// then fills the rest of the block with padding and compresses it, or, when fewer
// than nine bytes remain in the block, pads and compresses a second block as well.
// The eight digest words follow, word 0 first, one per accepted result transaction,
// last_word on word 7; after the eighth the block is ready for a new message. No
// clearing pass after reset.
module sha256_stream_hasher #(
	parameter int COUNT_WIDTH = shs_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_ready,
	input  shs_pkg::msg_t msg,
	output logic          dig_valid,
	input  logic          dig_ready,
	output shs_pkg::dig_t dig
);

	shs_pkg::cmd_t cmd;
	shs_pkg::sts_t sts;

	// sequencing
	shs_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.has_byte       (msg.has_byte),
		.end_of_message (msg.end_of_message),
		.dig_valid      (dig_valid),
		.dig_ready      (dig_ready),
		.sts            (sts),
		.cmd            (cmd)
	);

	// hashing datapath
	shs_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_byte (msg.data_byte),
		.cmd      (cmd),
		.sts      (sts),
		.dig      (dig)
	);

endmodule

FILE: rtl/shs_dp.sv
// sha-256 datapath: block window and schedule, round registers, hash words, byte counter
// depends on shs_pkg; driven by shs_ctrl through shs_pkg::cmd_t
module shs_dp #(
	parameter int COUNT_WIDTH = shs_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       msg_byte,
	input  shs_pkg::cmd_t    cmd,
	output shs_pkg::sts_t    sts,
	output shs_pkg::dig_t    dig
);

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	// window word 15 is the oldest: bytes 0 to 3 of the block, then W[t] while rounds run
	logic [15:0][31:0]      win_q;
	logic [31:0]            hash_q [8];
	logic [31:0]            v_q    [8];
	logic [COUNT_WIDTH-1:0] count_q;
	logic [5:0]             fill_q;

	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	logic [7:0]  shift_byte;
	logic [31:0] w_next;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;

	// length field, sent most significant byte first at positions 56 to 63
	assign len_bits = 64'({count_q, 3'b000});
	assign len_byte = 8'(len_bits >> {~fill_q[2:0], 3'b000});

	always_comb begin
		case (cmd.byte_sel)
			shs_pkg::BSEL_MSG:  shift_byte = msg_byte;
			shs_pkg::BSEL_PAD:  shift_byte = 8'h80;
			shs_pkg::BSEL_LEN:  shift_byte = len_byte;
			default:            shift_byte = 8'h00;
		endcase
	end

	// next schedule word from the sliding window
	assign w_next = win_q[15] + small_sig0(win_q[14]) + win_q[6] + small_sig1(win_q[1]);

	// round function
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_sig1(v_q[4]) + ch + shs_pkg::round_k(cmd.round_idx) + win_q[15];
	assign t2 = big_sig0(v_q[0]) + mj;

	// block window: bytes shift in while filling, schedule words while compressing
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			win_q <= {win_q[15][23:0], win_q[14:0], shift_byte};
		end else if (cmd.round_en) begin
			win_q <= {win_q[14:0], w_next};
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.vars_load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shs_pkg::init_h(3'(i));
			end
		end else if (cmd.hash_init) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= shs_pkg::init_h(3'(i));
			end
		end else if (cmd.hash_add) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	// message byte count and window fill position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.count_clr) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.shift_en) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign sts.fill = fill_q;

	// digest word selected by the controller
	assign dig.digest_word = hash_q[cmd.word_idx];
	assign dig.word_index  = cmd.word_idx;
	assign dig.last_word   = (cmd.word_idx == 3'd7);

endmodule

FILE: rtl/shs_ctrl.sv
// sha-256 controller: absorb, padding, round sequencing and digest output
// depends on shs_pkg; drives shs_dp through shs_pkg::cmd_t
module shs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_ready,
	input  logic          has_byte,
	input  logic          end_of_message,
	output logic          dig_valid,
	input  logic          dig_ready,
	input  shs_pkg::sts_t sts,
	output shs_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_ABSORB = 5'b00001,
		ST_PAD    = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;   // message is being finished
	logic       first_q; // 0x80 marker still to be written
	logic       len_q;   // current pad block carries the length field
	logic       fin_d;
	logic       first_d;
	logic       len_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		fin_d         = fin_q;
		first_d       = first_q;
		len_d         = len_q;
		msg_ready     = 1'b0;
		dig_valid     = 1'b0;
		cmd.shift_en  = 1'b0;
		cmd.byte_sel  = shs_pkg::BSEL_MSG;
		cmd.count_inc = 1'b0;
		cmd.count_clr = 1'b0;
		cmd.vars_load = 1'b0;
		cmd.round_en  = 1'b0;
		cmd.round_idx = rnd_q;
		cmd.hash_add  = 1'b0;
		cmd.hash_init = 1'b0;
		cmd.word_idx  = idx_q;
		case (state_q)
			ST_ABSORB: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					cmd.shift_en  = has_byte;
					cmd.count_inc = has_byte;
					if (has_byte && sts.fill == 6'd63) begin
						cmd.vars_load = 1'b1;
						fin_d         = end_of_message;
						first_d       = 1'b1;
						len_d         = 1'b0;
						state_d       = ST_ROUND;
					end else if (end_of_message) begin
						fin_d   = 1'b1;
						first_d = 1'b1;
						len_d   = 1'b0;
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.shift_en = 1'b1;
				if (first_q) begin
					cmd.byte_sel = shs_pkg::BSEL_PAD;
					first_d      = 1'b0;
					len_d        = (sts.fill <= 6'd55);
				end else if (len_q && sts.fill >= 6'd56) begin
					cmd.byte_sel = shs_pkg::BSEL_LEN;
				end else begin
					cmd.byte_sel = shs_pkg::BSEL_ZERO;
				end
				if (sts.fill == 6'd63) begin
					cmd.vars_load = 1'b1;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == 6'd63) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.hash_add = 1'b1;
				if (!fin_q) begin
					state_d = ST_ABSORB;
				end else if (len_q && !first_q) begin
					state_d = ST_EMIT;
				end else begin
					// marker still to come, or it went into a full block: one more block for the length
					if (!first_q) begin
						len_d = 1'b1;
					end
					state_d = ST_PAD;
				end
			end
			ST_EMIT: begin
				dig_valid = 1'b1;
				if (dig_ready && idx_q == 3'd7) begin
					cmd.hash_init = 1'b1;
					cmd.count_clr = 1'b1;
					fin_d         = 1'b0;
					len_d         = 1'b0;
					state_d       = ST_ABSORB;
				end
			end
			default: begin
				state_d = ST_ABSORB;
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
			rnd_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			first_q <= first_d;
			len_q   <= len_d;
			if (cmd.round_en) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (dig_valid && dig_ready) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// the last round always hands over to the hash update
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q == 6'd63 |=> state_q == ST_UPDATE)
		else $error("last round not followed by hash update");

	// digest output only follows a hash update
	a_emit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> $past(state_q) == ST_UPDATE)
		else $error("digest output entered from wrong state");

	// digest only after the marker and the length field have been compressed
	a_emit_padded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> fin_q && len_q && !first_q)
		else $error("digest output before padding complete");

	// compression starts on a full window
	a_round_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q == 6'd0 |-> sts.fill == 6'd0)
		else $error("compression started on a partly filled block");

	// digest words leave in order, starting at word zero
	a_idx_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> idx_q == 3'd0)
		else $error("digest output does not start at word zero");

endmodule
